// ===== rtl/frame_mirror_flip_core_defines.svh =====
// Assertion macros for the frame mirror core.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FRAME_MIRROR_FLIP_CORE_DEFINES_SVH
`define FRAME_MIRROR_FLIP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define FMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FMF_ASSERT(lbl, prop, msg)
`define FMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/fmf_pkg.sv =====
// Shared constants for the frame mirror core: frame geometry, field widths,
// configuration register codes, pixel size codes and a dimension clamp. No dependencies.
package fmf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int PIXEL_W = 24;
    localparam int DIM_W   = 9;
    localparam int PB_W    = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_H     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_V     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES  = 3'd4;

    localparam logic [PB_W-1:0] PB_GREY8  = 2'd1;
    localparam logic [PB_W-1:0] PB_GREY16 = 2'd2;
    localparam logic [PB_W-1:0] PB_RGB24  = 2'd3;

    localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

    // Zero counts as one, anything above the maximum counts as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/fmf_ifs.sv =====
// Valid/ready channel interfaces for the frame mirror core: request and
// response. Depends on fmf_pkg.
interface fmf_req_if
    import fmf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [PIXEL_W-1:0] pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface fmf_rsp_if
    import fmf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               read_status;
    logic               frame_end;

    modport source (output valid, output pixel_out, output read_status,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input read_status,
                    input frame_end, output ready);
endinterface

// ===== rtl/fmf_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module fmf_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/frame_mirror_flip_core.sv =====
// Frame mirror core: a read result passes through the store's registered
// read data, then the output register, before it reaches the sink.
// Sustained rate is one item per cycle while the sink is ready, set by the single store port.
// rst_n is asynchronous and active low; it clears counters, the loaded flag,
// the pipeline valids and the registers to their defaults. The frame store
// is not cleared and needs no clearing pass.
module frame_mirror_flip_core
    import fmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fmf_req_if.sink               req,
    fmf_rsp_if.source             rsp
);

`include "frame_mirror_flip_core_defines.svh"

    // Configuration registers.
    logic             mirror_h_reg;
    logic             mirror_v_reg;
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [PB_W-1:0]  pixel_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_h_reg     <= 1'b0;
            mirror_v_reg     <= 1'b0;
            frame_width_reg  <= DIM_W'(256);
            frame_height_reg <= DIM_W'(256);
            pixel_bytes_reg  <= PB_GREY8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIRROR_H:     mirror_h_reg     <= cfg_data[0];
                CFG_MIRROR_V:     mirror_v_reg     <= cfg_data[0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                CFG_PIXEL_BYTES:  pixel_bytes_reg  <= cfg_data[PB_W-1:0];
                default:          ;
            endcase
        end
    end

    // Frame position state.
    logic [ROW_W-1:0] load_row_reg, load_row_next;
    logic [COL_W-1:0] load_col_reg, load_col_next;
    logic             frame_loaded_reg, frame_loaded_next;
    logic [ROW_W-1:0] emit_row_reg, emit_row_next;
    logic [COL_W-1:0] emit_col_reg, emit_col_next;

    // Read pipeline: one read in flight whose data sits in the store's
    // output register, then the output register toward the sink.
    logic pend_reg;
    logic pend_status_reg;
    logic pend_last_reg;
    logic out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic out_status_reg;
    logic out_end_reg;

    logic advance;
    logic accept;
    logic is_read;
    logic ram_we;
    logic ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIXEL_W-1:0] ram_rdata;

    // Effective geometry and last valid positions.
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [DIM_W-1:0] col_last;
    logic [DIM_W-1:0] row_last;

    assign width_eff  = clamp_dim(frame_width_reg, DIM_MAX_W);
    assign height_eff = clamp_dim(frame_height_reg, DIM_MAX_H);
    assign col_last   = width_eff - DIM_W'(1);
    assign row_last   = height_eff - DIM_W'(1);

    // A counter that sits at or past the last position is treated as the last
    // position, so a shrunken frame ends cleanly.
    logic [COL_W-1:0] lc, ec, sc;
    logic [ROW_W-1:0] lr, er, sr;
    logic             lc_end, lr_end, ec_end, er_end;

    always_comb
    begin
        lc = (DIM_W'(load_col_reg) >= col_last) ? col_last[COL_W-1:0] : load_col_reg;
        lr = (DIM_W'(load_row_reg) >= row_last) ? row_last[ROW_W-1:0] : load_row_reg;
        ec = (DIM_W'(emit_col_reg) >= col_last) ? col_last[COL_W-1:0] : emit_col_reg;
        er = (DIM_W'(emit_row_reg) >= row_last) ? row_last[ROW_W-1:0] : emit_row_reg;
        lc_end = (DIM_W'(lc) == col_last);
        lr_end = (DIM_W'(lr) == row_last);
        ec_end = (DIM_W'(ec) == col_last);
        er_end = (DIM_W'(er) == row_last);
        // Mirrored source position of the pixel being emitted.
        sc = mirror_h_reg ? (col_last[COL_W-1:0] - ec) : ec;
        sr = mirror_v_reg ? (row_last[ROW_W-1:0] - er) : er;
    end

    // The pending read moves on whenever the output register is free or
    // being emptied; a new item is taken only when the pending slot frees.
    assign advance   = pend_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !pend_reg || advance;
    assign accept    = req.valid && req.ready;
    assign is_read   = req.req_type;

    // Writes go to the store only while the frame is loading; reads hit it
    // only once the frame is loaded, so the two never overlap on an entry.
    assign ram_we   = accept && !is_read && !frame_loaded_reg;
    assign ram_re   = accept && is_read && frame_loaded_reg;
    assign ram_addr = ram_we ? {lr, lc} : {sr, sc};

    fmf_ram #(
        .DATA_W (PIXEL_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (req.pixel_in),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        load_row_next     = load_row_reg;
        load_col_next     = load_col_reg;
        frame_loaded_next = frame_loaded_reg;
        emit_row_next     = emit_row_reg;
        emit_col_next     = emit_col_reg;
        if (ram_we)
        begin
            if (lc_end)
            begin
                load_col_next = '0;
                if (lr_end)
                begin
                    load_row_next     = '0;
                    frame_loaded_next = 1'b1;
                end
                else
                begin
                    load_row_next = lr + ROW_W'(1);
                end
            end
            else
            begin
                load_col_next = lc + COL_W'(1);
            end
        end
        if (ram_re)
        begin
            if (ec_end)
            begin
                emit_col_next = '0;
                if (er_end)
                begin
                    // Last pixel out frees the store for the next frame.
                    emit_row_next     = '0;
                    load_row_next     = '0;
                    load_col_next     = '0;
                    frame_loaded_next = 1'b0;
                end
                else
                begin
                    emit_row_next = er + ROW_W'(1);
                end
            end
            else
            begin
                emit_col_next = ec + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg     <= '0;
            load_col_reg     <= '0;
            frame_loaded_reg <= 1'b0;
            emit_row_reg     <= '0;
            emit_col_reg     <= '0;
        end
        else
        begin
            load_row_reg     <= load_row_next;
            load_col_reg     <= load_col_next;
            frame_loaded_reg <= frame_loaded_next;
            emit_row_reg     <= emit_row_next;
            emit_col_reg     <= emit_col_next;
        end
    end

    // Pending read control. A read before the frame is loaded still takes
    // the slot, carrying the not-ready status instead of store data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (accept && is_read)
        begin
            pend_reg <= 1'b1;
        end
        else if (advance)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_read)
        begin
            pend_status_reg <= !frame_loaded_reg;
            pend_last_reg   <= frame_loaded_reg && ec_end && er_end;
        end
    end

    // Bytes above the pixel size read back as zero.
    logic [PIXEL_W-1:0] byte_mask;

    always_comb
    begin
        case (pixel_bytes_reg)
            PB_GREY16: byte_mask = 24'h00FFFF;
            PB_RGB24:  byte_mask = 24'hFFFFFF;
            default:   byte_mask = 24'h0000FF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pixel_reg  <= pend_status_reg ? '0 : (ram_rdata & byte_mask);
            out_status_reg <= pend_status_reg;
            out_end_reg    <= pend_last_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pixel_out   = out_pixel_reg;
    assign rsp.read_status = out_status_reg;
    assign rsp.frame_end   = out_end_reg;

    // A frame only becomes loaded through a store write.
    `FMF_ASSERT(a_loaded_by_write, $rose(frame_loaded_reg) |-> $past(ram_we), "frame loaded without a write")
    // A blocked output must keep the in-flight read parked.
    `FMF_ASSERT_NEXT(a_pend_holds, pend_reg && out_valid_reg && !rsp.ready, pend_reg, "pending read lost")
    // Emitting the last pixel frees the store.
    `FMF_ASSERT_NEXT(a_last_frees, ram_re && ec_end && er_end, !frame_loaded_reg, "store not freed")
    // The end marker only comes with a valid pixel.
    `FMF_ASSERT(a_end_valid, rsp.valid && rsp.frame_end |-> !rsp.read_status, "frame end on not-ready read")

endmodule
